@@ hw/rtl/spimrf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI master register file package
// Register offsets, status bit positions and the per-access result word.
// ----------------------------------------------------------------------------
package spimrf_pkg;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [2:0] OFF_CONTROL = 3'd0;
	localparam logic [2:0] OFF_STATUS  = 3'd1;
	localparam logic [2:0] OFF_DATA    = 3'd2;
	localparam logic [2:0] OFF_EXT     = 3'd3;
	localparam logic [2:0] OFF_PARAM   = 3'd4;
	localparam logic [2:0] OFF_SELECT  = 3'd5;
	localparam logic [2:0] OFF_TIMING  = 3'd6;

	localparam int ST_WFULL  = 3;
	localparam int ST_WEMPTY = 2;
	localparam int ST_RFULL  = 1;
	localparam int ST_REMPTY = 0;

	localparam logic [7:0] STATUS_RESET = 8'h05;
	localparam logic [7:0] CS_MASK      = 8'h11;

	typedef struct packed {
		logic       pop;
		logic       hit;
		logic [7:0] rdata;
		logic       irq;
		logic       sel;
		logic       svalid;
		logic [7:0] sbyte;
	} res_t;

endpackage
`default_nettype wire

@@ hw/rtl/spimrf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spimrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/spimrf_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI master register bank and receive ring control
// Holds the bus registers and ring pointers, drives the ring RAM ports.
// ----------------------------------------------------------------------------
module spimrf_regs #(
	parameter int RX_DEPTH = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic                        req_type,
	input  wire logic [2:0]                  reg_offset,
	input  wire logic [7:0]                  write_data,
	input  wire logic [7:0]                  slave_byte,
	output logic                             ram_we,
	output logic      [$clog2(RX_DEPTH)-1:0] ram_waddr,
	output logic      [7:0]                  ram_wdata,
	output logic                             ram_re,
	output logic      [$clog2(RX_DEPTH)-1:0] ram_raddr,
	output spimrf_pkg::res_t                 res
);

	localparam int PTR_W = $clog2(RX_DEPTH);

	logic [7:0]          control_q, status_q, ext_q, param_q, select_q, timing_q;
	logic [PTR_W-1:0]    wptr_q, rptr_q;
	logic                irq_q, sel_q;
	logic [RX_DEPTH-1:0] vld_q;

	logic [7:0]       status_n;
	logic [PTR_W-1:0] wptr_n, rptr_n;
	logic             irq_n, sel_n;
	logic             is_wr, is_data, push, pop;
	logic [7:0]       reg_rdata;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		ring_next = (p == PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		is_wr   = (req_type == spimrf_pkg::REQ_WRITE);
		is_data = (reg_offset == spimrf_pkg::OFF_DATA);
		push    = accept && is_wr && is_data && !status_q[spimrf_pkg::ST_RFULL];
		pop     = accept && !is_wr && is_data && !status_q[spimrf_pkg::ST_REMPTY];
		wptr_n  = push ? ring_next(wptr_q) : wptr_q;
		rptr_n  = pop ? ring_next(rptr_q) : rptr_q;

		status_n = status_q;
		irq_n    = irq_q;
		sel_n    = sel_q;
		if (accept && is_wr && reg_offset == spimrf_pkg::OFF_STATUS) begin
			status_n = status_q & ~write_data;
		end
		if (accept && is_data) begin
			status_n[spimrf_pkg::ST_WFULL]  = 1'b0;
			status_n[spimrf_pkg::ST_WEMPTY] = 1'b1;
			status_n[spimrf_pkg::ST_REMPTY] = (wptr_n == rptr_n);
			status_n[spimrf_pkg::ST_RFULL]  = (ring_next(wptr_n) == rptr_n);
			irq_n = status_n[spimrf_pkg::ST_RFULL];
		end
		if (accept && is_wr && reg_offset == spimrf_pkg::OFF_SELECT) begin
			sel_n = ((write_data & spimrf_pkg::CS_MASK) == spimrf_pkg::CS_MASK);
		end

		unique case (reg_offset)
			spimrf_pkg::OFF_CONTROL: reg_rdata = control_q;
			spimrf_pkg::OFF_STATUS:  reg_rdata = status_q;
			spimrf_pkg::OFF_EXT:     reg_rdata = ext_q;
			spimrf_pkg::OFF_PARAM:   reg_rdata = param_q;
			spimrf_pkg::OFF_SELECT:  reg_rdata = select_q;
			spimrf_pkg::OFF_TIMING:  reg_rdata = timing_q;
			default:                 reg_rdata = 8'h00;
		endcase

		res.pop    = pop;
		res.hit    = vld_q[rptr_q];
		res.rdata  = is_wr ? 8'h00 : reg_rdata;
		res.irq    = irq_n;
		res.sel    = sel_n;
		res.svalid = is_wr && is_data;
		res.sbyte  = (is_wr && is_data) ? write_data : 8'h00;
	end

	assign ram_we    = push;
	assign ram_waddr = wptr_q;
	assign ram_wdata = slave_byte;
	assign ram_re    = pop;
	assign ram_raddr = rptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= 8'h00;
			status_q  <= spimrf_pkg::STATUS_RESET;
			ext_q     <= 8'h00;
			param_q   <= 8'h00;
			select_q  <= 8'h00;
			timing_q  <= 8'h00;
			wptr_q    <= '0;
			rptr_q    <= '0;
			irq_q     <= 1'b0;
			sel_q     <= 1'b0;
			vld_q     <= '0;
		end else begin
			status_q <= status_n;
			wptr_q   <= wptr_n;
			rptr_q   <= rptr_n;
			irq_q    <= irq_n;
			sel_q    <= sel_n;
			if (push) begin
				vld_q[wptr_q] <= 1'b1;
			end
			if (accept && is_wr) begin
				unique case (reg_offset)
					spimrf_pkg::OFF_CONTROL: control_q <= write_data;
					spimrf_pkg::OFF_EXT:     ext_q     <= write_data;
					spimrf_pkg::OFF_PARAM:   param_q   <= write_data;
					spimrf_pkg::OFF_SELECT:  select_q  <= write_data;
					spimrf_pkg::OFF_TIMING:  timing_q  <= write_data;
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/spi_master_register_file_rx_fifo_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPI master register file with receive ring
// Byte-wide bus register block; data accesses push to or pop from a RAM ring.
// ----------------------------------------------------------------------------
// One bus access is accepted every cycle while the output is not stalled;
// its result word appears in the output register in the cycle after
// acceptance, when the registered read of the ring RAM returns the popped
// byte. Register and pointer updates complete at acceptance, so back-to-back
// accesses see each other's effects with no stall. The ring holds RX_DEPTH
// slots of which RX_DEPTH-1 are usable; slots never written since reset read
// as zero. Push and pop are gated by the stored status bits, so software that
// clears them through the status register can overrun or underrun the ring.
module spi_master_register_file_rx_fifo_unit #(
	parameter int RX_DEPTH = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       req_type,
	input  wire logic [2:0] reg_offset,
	input  wire logic [7:0] write_data,
	input  wire logic [7:0] slave_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] read_data,
	output logic            irq_level,
	output logic            select_level,
	output logic            send_valid,
	output logic      [7:0] send_byte
);

	localparam int PTR_W = $clog2(RX_DEPTH);

	logic             accept;
	logic             ram_we, ram_re;
	logic [PTR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]       ram_wdata, ram_rdata;
	spimrf_pkg::res_t res, res_s1;
	logic             valid_q;

	assign in_ready = !valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	spimrf_regs #(
		.RX_DEPTH(RX_DEPTH)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (req_type),
		.reg_offset(reg_offset),
		.write_data(write_data),
		.slave_byte(slave_byte),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.res       (res)
	);

	spimrf_ram #(
		.WIDTH(8),
		.DEPTH(RX_DEPTH)
	) u_rx_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	assign out_valid    = valid_q;
	assign read_data    = res_s1.pop ? (res_s1.hit ? ram_rdata : 8'h00) : res_s1.rdata;
	assign irq_level    = res_s1.irq;
	assign select_level = res_s1.sel;
	assign send_valid   = res_s1.svalid;
	assign send_byte    = res_s1.sbyte;

endmodule
`default_nettype wire

@@ dv/spi_master_register_file_rx_fifo_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master register file testbench
// Drives byte-wide bus accesses into the register block and checks every
// result word against a cycle-free model of the registers, the status bits
// and the receive ring. Directed tests cover register extremes, chip select,
// ring fill with overrun past the full bit, and a forced pop with the empty
// bit cleared; random traffic mixes data bursts, status clears and register
// accesses. Both handshakes idle at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module spi_master_register_file_rx_fifo_unit_test;

	localparam logic [2:0] OFF_UNMAPPED = 3'd7;
	localparam int RING_SLOTS = 8;
	localparam int RANDOM_WORDS = 1400;
	localparam int DRAIN_LIMIT = 20000;

	typedef struct packed {
		logic [7:0] rdata;
		logic       irq;
		logic       sel;
		logic       svalid;
		logic [7:0] sbyte;
	} access_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       req_type = spimrf_pkg::REQ_READ;
	logic [2:0] reg_offset = spimrf_pkg::OFF_CONTROL;
	logic [7:0] write_data = 8'h00;
	logic [7:0] slave_byte = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] read_data;
	logic       irq_level;
	logic       select_level;
	logic       send_valid;
	logic [7:0] send_byte;

	bit steady = 1'b0;
	int fail_count = 0;
	access_result_t due_results[$];

	logic [7:0] control_q;
	logic [7:0] status_q;
	logic [7:0] ext_q;
	logic [7:0] param_q;
	logic [7:0] select_q;
	logic [7:0] timing_q;
	logic [7:0] rx_slots [RING_SLOTS];
	logic [2:0] rx_wr;
	logic [2:0] rx_rd;
	logic       irq_q;
	logic       select_line_q;

	always #2 clk = ~clk;

	spi_master_register_file_rx_fifo_unit #(
		.RX_DEPTH(RING_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.reg_offset(reg_offset),
		.write_data(write_data),
		.slave_byte(slave_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.irq_level(irq_level),
		.select_level(select_level),
		.send_valid(send_valid),
		.send_byte(send_byte)
	);

	function automatic void refresh_rx_status();
		logic [2:0] wr_next;
		wr_next = rx_wr + 3'd1;
		status_q[spimrf_pkg::ST_WFULL] = 1'b0;
		status_q[spimrf_pkg::ST_WEMPTY] = 1'b1;
		status_q[spimrf_pkg::ST_REMPTY] = (rx_wr == rx_rd);
		status_q[spimrf_pkg::ST_RFULL] = (wr_next == rx_rd);
		irq_q = status_q[spimrf_pkg::ST_RFULL];
	endfunction

	function automatic access_result_t predict_access(input logic rq, input logic [2:0] off,
			input logic [7:0] wd, input logic [7:0] sb);
		access_result_t r;
		r = '0;
		if (rq == spimrf_pkg::REQ_WRITE) begin
			case (off)
				spimrf_pkg::OFF_CONTROL: control_q = wd;
				spimrf_pkg::OFF_STATUS: status_q = status_q & ~wd;
				spimrf_pkg::OFF_DATA: begin
					r.svalid = 1'b1;
					r.sbyte = wd;
					if (!status_q[spimrf_pkg::ST_RFULL]) begin
						rx_slots[rx_wr] = sb;
						rx_wr = rx_wr + 3'd1;
					end
					refresh_rx_status();
				end
				spimrf_pkg::OFF_EXT: ext_q = wd;
				spimrf_pkg::OFF_PARAM: param_q = wd;
				spimrf_pkg::OFF_SELECT: begin
					select_line_q = ((wd & spimrf_pkg::CS_MASK) == spimrf_pkg::CS_MASK);
					select_q = wd;
				end
				spimrf_pkg::OFF_TIMING: timing_q = wd;
				default: ;
			endcase
		end else begin
			case (off)
				spimrf_pkg::OFF_CONTROL: r.rdata = control_q;
				spimrf_pkg::OFF_STATUS: r.rdata = status_q;
				spimrf_pkg::OFF_DATA: begin
					if (!status_q[spimrf_pkg::ST_REMPTY]) begin
						r.rdata = rx_slots[rx_rd];
						rx_rd = rx_rd + 3'd1;
					end
					refresh_rx_status();
				end
				spimrf_pkg::OFF_EXT: r.rdata = ext_q;
				spimrf_pkg::OFF_PARAM: r.rdata = param_q;
				spimrf_pkg::OFF_SELECT: r.rdata = select_q;
				spimrf_pkg::OFF_TIMING: r.rdata = timing_q;
				default: ;
			endcase
		end
		r.irq = irq_q;
		r.sel = select_line_q;
		return r;
	endfunction

	task automatic send_access(input logic rq, input logic [2:0] off, input logic [7:0] wd,
			input logic [7:0] sb);
		while (!steady && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		reg_offset <= off;
		write_data <= wd;
		slave_byte <= sb;
		do @(posedge clk); while (!in_ready);
		due_results.push_back(predict_access(rq, off, wd, sb));
	endtask

	task automatic settle_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= steady || ($urandom_range(99) >= 38);
	end

	always @(posedge clk) begin : result_check
		access_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				fail_count++;
				$display("%0t: result word with none expected, read_data %0h", $time, read_data);
			end else begin
				want = due_results.pop_front();
				check_field("read_data", want.rdata, read_data);
				check_field("irq_level", 8'(want.irq), 8'(irq_level));
				check_field("select_level", 8'(want.sel), 8'(select_level));
				check_field("send_valid", 8'(want.svalid), 8'(send_valid));
				check_field("send_byte", want.sbyte, send_byte);
			end
		end
	end

	task automatic test_register_file();
		send_access(spimrf_pkg::REQ_WRITE, spimrf_pkg::OFF_CONTROL, 8'hFF, 8'h00);
		send_access(spimrf_pkg::REQ_WRITE, spimrf_pkg::OFF_TIMING, 8'hFF, 8'hFF);
		send_access(spimrf_pkg::REQ_WRITE, OFF_UNMAPPED, 8'hFF, 8'hFF);
		send_access(spimrf_pkg::REQ_READ, spimrf_pkg::OFF_CONTROL, 8'h00, 8'h00);
		send_access(spimrf_pkg::REQ_READ, spimrf_pkg::OFF_TIMING, 8'h00, 8'h00);
		send_access(spimrf_pkg::REQ_READ, OFF_UNMAPPED, 8'h00, 8'h00);
	endtask

	task automatic test_chip_select();
		send_access(spimrf_pkg::REQ_WRITE, spimrf_pkg::OFF_SELECT, spimrf_pkg::CS_MASK, 8'h00);
		send_access(spimrf_pkg::REQ_READ, spimrf_pkg::OFF_SELECT, 8'h00, 8'h00);
		send_access(spimrf_pkg::REQ_WRITE, spimrf_pkg::OFF_SELECT, 8'hEF, 8'h00);
	endtask

	task automatic test_ring_overrun();
		int i;
		// fill to the full bit, then one more word that must be dropped
		for (i = 0; i < RING_SLOTS; i++)
			send_access(spimrf_pkg::REQ_WRITE, spimrf_pkg::OFF_DATA,
				(i == RING_SLOTS - 1) ? 8'hFF : 8'(i * 33), 8'(8'hA0 + i));
		// clear every status bit and push past the full mark
		send_access(spimrf_pkg::REQ_WRITE, spimrf_pkg::OFF_STATUS, 8'hFF, 8'h00);
		send_access(spimrf_pkg::REQ_WRITE, spimrf_pkg::OFF_DATA, 8'h5A, 8'hFF);
		send_access(spimrf_pkg::REQ_READ, spimrf_pkg::OFF_STATUS, 8'h00, 8'h00);
	endtask

	task automatic test_read_gate();
		send_access(spimrf_pkg::REQ_READ, spimrf_pkg::OFF_DATA, 8'h00, 8'h00);
		send_access(spimrf_pkg::REQ_WRITE, spimrf_pkg::OFF_STATUS,
			8'(1 << spimrf_pkg::ST_REMPTY), 8'h00);
		send_access(spimrf_pkg::REQ_READ, spimrf_pkg::OFF_DATA, 8'h00, 8'h00);
		send_access(spimrf_pkg::REQ_READ, spimrf_pkg::OFF_STATUS, 8'h00, 8'h00);
	endtask

	task automatic test_random_traffic();
		int sent;
		int mode;
		int burst;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			steady = (sent >= 500 && sent < 800);
			mode = $urandom_range(99);
			burst = $urandom_range(1, 9);
			if (mode < 35) begin
				repeat (burst) begin
					send_access(spimrf_pkg::REQ_WRITE, spimrf_pkg::OFF_DATA,
						8'($urandom_range(255)), 8'($urandom_range(255)));
					sent++;
				end
			end else if (mode < 70) begin
				repeat (burst) begin
					send_access(spimrf_pkg::REQ_READ, spimrf_pkg::OFF_DATA,
						8'($urandom_range(255)), 8'($urandom_range(255)));
					sent++;
				end
			end else if (mode < 78) begin
				send_access(spimrf_pkg::REQ_WRITE, spimrf_pkg::OFF_STATUS,
					8'($urandom_range(255)), 8'($urandom_range(255)));
				sent++;
			end else if (mode < 92) begin
				send_access(1'($urandom_range(1)), 3'($urandom_range(7)),
					8'($urandom_range(255)), 8'($urandom_range(255)));
				sent++;
			end else begin
				send_access(spimrf_pkg::REQ_READ, spimrf_pkg::OFF_STATUS,
					8'($urandom_range(255)), 8'($urandom_range(255)));
				sent++;
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		int waited;
		control_q = 8'h00;
		status_q = spimrf_pkg::STATUS_RESET;
		ext_q = 8'h00;
		param_q = 8'h00;
		select_q = 8'h00;
		timing_q = 8'h00;
		foreach (rx_slots[i])
			rx_slots[i] = 8'h00;
		rx_wr = 3'd0;
		rx_rd = 3'd0;
		irq_q = 1'b0;
		select_line_q = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_file();
		settle_results();
		test_chip_select();
		settle_results();
		test_ring_overrun();
		settle_results();
		test_read_gate();
		settle_results();
		test_random_traffic();
		in_valid <= 1'b0;
		waited = 0;
		while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (due_results.size() != 0) begin
			fail_count++;
			$display("%0t: %0d result words never arrived", $time, due_results.size());
		end
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("** spi_master_register_file_rx_fifo_unit: PASSED **");
		else
			$display("** spi_master_register_file_rx_fifo_unit: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("** spi_master_register_file_rx_fifo_unit: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/spimrf_pkg.sv
hw/rtl/spimrf_ram.sv
hw/rtl/spimrf_regs.sv
hw/rtl/spi_master_register_file_rx_fifo_unit.sv
dv/spi_master_register_file_rx_fifo_unit_test.sv
